// ===== rtl/core/bpbb_pkg.sv =====
// Shared types and constants for the MSB-first bit packer with byte budget.
`timescale 1ns / 1ps

package bpbb_pkg;

    // Widest code that is packed; wider requests saturate to this.
    localparam logic [4:0] MAX_CODE_WIDTH = 5'd16;

    // Free bits in an empty partial byte.
    localparam logic [3:0] FREE_EMPTY = 4'd8;

    // Byte address of the budget register.
    localparam logic [1:0] ADDR_BYTE_BUDGET = 2'd0;

    // One input item.
    typedef struct packed {
        logic [4:0]  code_width;
        logic [15:0] code_value;
    } code_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  byte_count;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic        over_limit;
        logic [31:0] bytes_written;
    } result_t;

    // Packing outcome handed from the packer to the budget gate.
    typedef struct packed {
        logic [1:0] completed;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] partial_next;
        logic [3:0] free_next;
    } pack_t;

endpackage

// ===== rtl/core/bpbb_pack.sv =====
// Appends one code to the partial byte and reports the bytes it completes.
`timescale 1ns / 1ps

module bpbb_pack
(
    input  logic [7:0]        partial,
    input  logic [3:0]        free,
    input  bpbb_pkg::code_t   code_item,
    output bpbb_pkg::pack_t   pack
);

    logic [4:0]  n;
    logic [15:0] x;
    logic [4:0]  free_wide;
    logic [4:0]  diff;
    logic [4:0]  rest;
    logic [15:0] hi_part;
    logic [15:0] lo_part;
    logic [23:0] tail;
    logic [4:0]  free_calc;

    always_comb
    begin
        // Saturate the width and mask off bits above it.
        n = (code_item.code_width > bpbb_pkg::MAX_CODE_WIDTH) ?
            bpbb_pkg::MAX_CODE_WIDTH : code_item.code_width;
        if (n == bpbb_pkg::MAX_CODE_WIDTH)
        begin
            x = code_item.code_value;
        end
        else
        begin
            x = code_item.code_value & ((16'd1 << n[3:0]) - 16'd1);
        end

        free_wide = {1'b0, free};
        diff      = free_wide - n;
        rest      = n - free_wide;
        hi_part   = x >> rest[3:0];
        lo_part   = x >> 4'(rest[3:0] - 4'd8);

        pack.byte0 = 8'd0;
        pack.byte1 = 8'd0;
        pack.completed = 2'd0;

        if (n < free_wide)
        begin
            // Code fits in the partial byte: no byte completes.
            free_calc         = diff;
            tail              = 24'(x) << free_calc[3:0];
            pack.partial_next = partial | tail[7:0];
        end
        else
        begin
            pack.byte0 = partial | hi_part[7:0];
            if (rest < 5'd8)
            begin
                pack.completed = 2'd1;
                free_calc      = 5'd8 - rest;
            end
            else
            begin
                pack.completed = 2'd2;
                pack.byte1     = lo_part[7:0];
                free_calc      = 5'd16 - rest;
            end
            tail              = 24'(x) << free_calc[3:0];
            pack.partial_next = tail[7:0];
        end
        pack.free_next = free_calc[3:0];
    end

endmodule

// ===== rtl/core/bpbb_gate.sv =====
// Applies the byte budget to completed bytes and updates the counters.
`timescale 1ns / 1ps

module bpbb_gate
(
    input  bpbb_pkg::pack_t   pack,
    input  logic [31:0]       emitted,
    input  logic              dropped,
    input  logic [31:0]       budget,
    output bpbb_pkg::result_t res
);

    logic       room0;
    logic       room1;
    logic [1:0] got;

    always_comb
    begin
        room0 = emitted < budget;
        room1 = (33'(emitted) + 33'd1) < 33'(budget);

        case (pack.completed)
            2'd1:    got = room0 ? 2'd1 : 2'd0;
            2'd2:    got = room0 ? (room1 ? 2'd2 : 2'd1) : 2'd0;
            default: got = 2'd0;
        endcase

        res.byte_count    = got;
        res.first_byte    = (got != 2'd0) ? pack.byte0 : 8'd0;
        res.second_byte   = (got == 2'd2) ? pack.byte1 : 8'd0;
        // Any completed byte past the budget sets the sticky flag.
        res.over_limit    = dropped | (got != pack.completed);
        res.bytes_written = emitted + 32'(got);
    end

endmodule

// ===== rtl/core/bit_packer_with_byte_budget.sv =====
// Top level of the MSB-first bit packer with byte budget.
`timescale 1ns / 1ps

// Usage:
//   Codes enter on the code channel (code_valid / code_ready / code_item), each
//   holding code_width (0..16, larger saturates to 16) and code_value. The code
//   bits are appended most significant bit first to a running byte stream.
//   Each code yields one transfer on the result channel (res_valid / res_ready /
//   res_item): how many bytes it completed and emitted (0..2), those bytes, the
//   sticky over-limit flag and the running count of emitted bytes.
//   Bytes are emitted only while the emitted count is below byte_budget; beyond
//   it they are dropped, the flag sets, and bit alignment carries on unchanged.
//   byte_budget is written over the APB port at address 0; the user must do so only
//   while idle, as the block does not enforce it.
// Timing:
//   A code passes the input register, then the result register. Throughput is one
//   code per cycle while res_ready stays high; the packing and budget logic is a
//   single short combinational pass between the two registers.
// Reset and stall:
//   rst_n clears the partial byte, sets eight free bits, zeroes the emitted
//   count, the flag and the budget. While a held result waits on res_ready, the result
//   register holds; one more code is still taken into the input register, then
//   code_ready drops until the result drains.

module bit_packer_with_byte_budget
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                code_valid,
    output logic                code_ready,
    input  bpbb_pkg::code_t     code_item,

    output logic                res_valid,
    input  logic                res_ready,
    output bpbb_pkg::result_t   res_item,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration.
    logic [31:0]       budget_reg;

    // Packing state.
    logic [7:0]        partial_reg;
    logic [3:0]        free_reg;
    logic [31:0]       emitted_reg;
    logic              dropped_reg;

    // Input register stage.
    logic              code_valid_reg;
    bpbb_pkg::code_t   code_reg;

    // Result register stage.
    logic              res_valid_reg;
    bpbb_pkg::result_t res_reg;
    bpbb_pkg::result_t res_next;

    bpbb_pkg::pack_t   pack;
    logic              advance;
    logic              cfg_write;

    // Move the held code into the result register when that slot is free
    // or being drained this cycle.
    assign advance    = code_valid_reg && (!res_valid_reg || res_ready);
    assign code_ready = !code_valid_reg || advance;

    assign res_valid  = res_valid_reg;
    assign res_item   = res_reg;

    // APB: pready is tied high, single register.
    assign pready    = 1'b1;
    assign prdata    = budget_reg;
    assign cfg_write = psel && penable && pwrite && (paddr == bpbb_pkg::ADDR_BYTE_BUDGET);

    bpbb_pack u_pack
    (
        .partial   (partial_reg),
        .free      (free_reg),
        .code_item (code_reg),
        .pack      (pack)
    );

    bpbb_gate u_gate
    (
        .pack    (pack),
        .emitted (emitted_reg),
        .dropped (dropped_reg),
        .budget  (budget_reg),
        .res     (res_next)
    );

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg     <= 32'd0;
            partial_reg    <= 8'd0;
            free_reg       <= bpbb_pkg::FREE_EMPTY;
            emitted_reg    <= 32'd0;
            dropped_reg    <= 1'b0;
            code_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                budget_reg <= pwdata;
            end

            if (code_ready)
            begin
                code_valid_reg <= code_valid;
            end

            if (advance)
            begin
                // Advance packing state; dropped bytes still consume bits.
                partial_reg   <= pack.partial_next;
                free_reg      <= pack.free_next;
                emitted_reg   <= res_next.bytes_written;
                dropped_reg   <= res_next.over_limit;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load only on a transfer into each stage.
    always_ff @(posedge clk)
    begin
        if (code_ready && code_valid)
        begin
            code_reg <= code_item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule
